>>> rtl/core/rrpt_pkg.sv
package rrpt_pkg;

  localparam int MAX_ENTRIES = 10;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int OP_W     = 3;
  localparam int ID_W     = 16;
  localparam int PSTATE_W = 2;
  localparam int BURST_IN_W = 15;
  localparam int BURST_W  = 16;
  localparam int STATUS_W = 3;

  localparam logic signed [BURST_W-1:0] BURST_MIN = {1'b1, {(BURST_W-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 3'd0,
    OP_ADD   = 3'd1,
    OP_TICK  = 3'd2,
    OP_SET   = 3'd3,
    OP_LIST  = 3'd4,
    OP_SHOW  = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_RAN     = 3'd3,
    ST_LIST    = 3'd4,
    ST_CURRENT = 3'd5
  } status_t;

  typedef enum logic [PSTATE_W-1:0] {
    PS_READY      = 2'd0,
    PS_RUNNING    = 2'd1,
    PS_TERMINATED = 2'd2,
    PS_OTHER      = 2'd3
  } pstate_t;

  typedef struct packed {
    logic [ID_W-1:0]            id;
    logic [PSTATE_W-1:0]        state;
    logic signed [BURST_W-1:0]  burst;
  } entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0]        status;
    logic [ID_W-1:0]            entry_id;
    logic [PSTATE_W-1:0]        entry_state;
    logic signed [BURST_W-1:0]  entry_burst;
    logic                       terminated_now;
    logic                       last;
  } rsp_t;

endpackage

>>> rtl/core/rrpt_if.sv
interface rrpt_req_if;
  import rrpt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       opcode;
  logic [ID_W-1:0]       proc_id;
  logic [PSTATE_W-1:0]   state_in;
  logic [BURST_IN_W-1:0] burst_in;

  modport source (output valid, opcode, proc_id, state_in, burst_in, input ready);
  modport sink   (input valid, opcode, proc_id, state_in, burst_in, output ready);
endinterface

interface rrpt_rsp_if;
  import rrpt_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic [ID_W-1:0]            entry_id;
  logic [PSTATE_W-1:0]        entry_state;
  logic signed [BURST_W-1:0]  entry_burst;
  logic                       terminated_now;
  logic                       last;

  modport source (output valid, status, entry_id, entry_state, entry_burst,
                  terminated_now, last, input ready);
  modport sink   (input valid, status, entry_id, entry_state, entry_burst,
                  terminated_now, last, output ready);
endinterface

>>> rtl/core/rrpt_out_buf.sv
module rrpt_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rrpt_pkg::rsp_t  push_data,
  output logic            push_ready,
  rrpt_rsp_if.source      out_ch
);
  import rrpt_pkg::*;

  logic vld_r;
  rsp_t data_r;

  assign push_ready = !vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (push_ready) begin
      vld_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      data_r <= push_data;
    end
  end

  assign out_ch.valid          = vld_r;
  assign out_ch.status         = data_r.status;
  assign out_ch.entry_id       = data_r.entry_id;
  assign out_ch.entry_state    = data_r.entry_state;
  assign out_ch.entry_burst    = data_r.entry_burst;
  assign out_ch.terminated_now = data_r.terminated_now;
  assign out_ch.last           = data_r.last;
endmodule

>>> rtl/core/round_robin_process_table_unit.sv
// Round-robin process table: each request item yields one or more result items on out_ch,
// the final one flagged by last. Clear, add, unused opcodes and requests on an empty table
// report straight from the idle state; tick and show current first read the table entry,
// then update and report; set state walks the table one entry per cycle until a match or
// the last entry; list streams one result per cycle while out_ch does not stall. The read
// step comes from the entry memory (one read and one write port) with its registered read.
// A new request is taken only once the previous one has handed its last result to the
// output register. Table contents are not cleared at reset; entries are only read after
// they were written.
module round_robin_process_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  rrpt_req_if.sink    in_ch,
  rrpt_rsp_if.source  out_ch
);
  import rrpt_pkg::*;

  // one-hot sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_TICK = 5'b00010,
    S_SHOW = 5'b00100,
    S_SET  = 5'b01000,
    S_LIST = 5'b10000
  } fsm_t;

  fsm_t state_r, state_nxt;

  logic [CNT_W-1:0]    cnt_r, cnt_nxt;      // entries in the table
  logic [IDX_W-1:0]    ptr_r, ptr_nxt;      // run pointer
  logic [IDX_W-1:0]    idx_r, idx_nxt;      // entry under work (scan or tick)
  logic [ID_W-1:0]     pid_r, pid_nxt;      // saved search id for set state
  logic [PSTATE_W-1:0] st_r, st_nxt;        // saved state code for set state

  // entry memory, one read and one write port, registered read
  entry_t              mem [MAX_ENTRIES];
  entry_t              rd_q_r;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  entry_t              wr_data;

  // result path into the output register
  logic                push;
  rsp_t                push_data;
  logic                push_ready;

  logic                accept;
  logic [CNT_W-1:0]    idx_inc;
  logic                idx_at_end;
  logic [IDX_W-1:0]    cur_idx;
  logic                tbl_empty;
  logic                tbl_full;
  logic signed [BURST_W-1:0] burst_dec;
  logic                term;

  assign in_ch.ready = (state_r == S_IDLE) && push_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign tbl_empty  = (cnt_r == '0);
  assign tbl_full   = (cnt_r == CNT_W'(MAX_ENTRIES));
  assign idx_inc    = CNT_W'(idx_r) + CNT_W'(1);
  assign idx_at_end = (idx_inc == cnt_r);
  // a pointer past the fill falls back to entry zero
  assign cur_idx    = (CNT_W'(ptr_r) < cnt_r) ? ptr_r : '0;

  // tick arithmetic on the entry just read, decrement saturates at the minimum
  assign burst_dec = (rd_q_r.burst == BURST_MIN) ? rd_q_r.burst
                                                 : rd_q_r.burst - 16'sd1;
  assign term      = burst_dec[BURST_W-1] || (burst_dec == '0);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ptr_nxt   = ptr_r;
    idx_nxt   = idx_r;
    pid_nxt   = pid_r;
    st_nxt    = st_r;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = rd_q_r;
    push      = 1'b0;
    push_data = '0;
    push_data.last = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(in_ch.opcode))
            OP_CLEAR: begin
              cnt_nxt = '0;
              ptr_nxt = '0;
              push    = 1'b1;
              push_data.status = ST_OK;
            end
            OP_ADD: begin
              push = 1'b1;
              if (tbl_full) begin
                push_data.status = ST_FULL;
              end else begin
                push_data.status = ST_OK;
                wr_en         = 1'b1;
                wr_addr       = cnt_r[IDX_W-1:0];
                wr_data.id    = in_ch.proc_id;
                wr_data.state = in_ch.state_in;
                wr_data.burst = {1'b0, in_ch.burst_in};
                cnt_nxt       = cnt_r + CNT_W'(1);
              end
            end
            OP_TICK, OP_SHOW: begin
              if (tbl_empty) begin
                push = 1'b1;
                push_data.status = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = cur_idx;
                idx_nxt   = cur_idx;
                state_nxt = (op_t'(in_ch.opcode) == OP_TICK) ? S_TICK : S_SHOW;
              end
            end
            OP_SET: begin
              if (tbl_empty) begin
                push = 1'b1;
                push_data.status = ST_OK;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                idx_nxt   = '0;
                pid_nxt   = in_ch.proc_id;
                st_nxt    = in_ch.state_in;
                state_nxt = S_SET;
              end
            end
            OP_LIST: begin
              if (tbl_empty) begin
                push = 1'b1;
                push_data.status = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                idx_nxt   = '0;
                state_nxt = S_LIST;
              end
            end
            default: begin
              // unused opcode
              push = 1'b1;
              push_data.status = ST_OK;
            end
          endcase
        end
      end

      S_TICK: begin
        if (push_ready) begin
          push          = 1'b1;
          wr_en         = 1'b1;
          wr_data.burst = burst_dec;
          wr_data.state = term ? PS_TERMINATED : PS_READY;
          push_data.status         = ST_RAN;
          push_data.entry_id       = rd_q_r.id;
          push_data.entry_state    = term ? PS_TERMINATED : PS_READY;
          push_data.entry_burst    = burst_dec;
          push_data.terminated_now = term;
          ptr_nxt   = idx_at_end ? '0 : idx_inc[IDX_W-1:0];
          state_nxt = S_IDLE;
        end
      end

      S_SHOW: begin
        if (push_ready) begin
          push = 1'b1;
          push_data.status      = ST_CURRENT;
          push_data.entry_id    = rd_q_r.id;
          push_data.entry_state = rd_q_r.state;
          push_data.entry_burst = rd_q_r.burst;
          state_nxt = S_IDLE;
        end
      end

      S_SET: begin
        if (rd_q_r.id == pid_r) begin
          // first match wins, only the state field changes
          if (push_ready) begin
            wr_en         = 1'b1;
            wr_data.state = st_r;
            push          = 1'b1;
            push_data.status = ST_OK;
            state_nxt     = S_IDLE;
          end
        end else if (idx_at_end) begin
          if (push_ready) begin
            push = 1'b1;
            push_data.status = ST_OK;
            state_nxt = S_IDLE;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_inc[IDX_W-1:0];
          idx_nxt = idx_inc[IDX_W-1:0];
        end
      end

      S_LIST: begin
        if (push_ready) begin
          push = 1'b1;
          push_data.status      = ST_LIST;
          push_data.entry_id    = rd_q_r.id;
          push_data.entry_state = rd_q_r.state;
          push_data.entry_burst = rd_q_r.burst;
          push_data.last        = idx_at_end;
          if (idx_at_end) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_inc[IDX_W-1:0];
            idx_nxt = idx_inc[IDX_W-1:0];
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ptr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    pid_r <= pid_nxt;
    st_r  <= st_nxt;
  end

  // table memory; accesses never overlap on one entry, a write always
  // completes before the next read is issued
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  rrpt_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .out_ch     (out_ch)
  );
endmodule
